FILE: rtl/iira_pkg.sv
// ---------------------------------------------------------------------------
// iira_pkg
// Shared widths, operation and status codes, and the control bundle that
// the top level broadcasts to every storage cell of the insert/remove array.
// ---------------------------------------------------------------------------
`default_nettype none

package iira_pkg;

   localparam int CAPACITY_DEFAULT = 16;

   localparam int KIND_WIDTH   = 2;
   localparam int POS_WIDTH    = 8;
   localparam int DATA_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int FILL_WIDTH   = 5;

   localparam logic [KIND_WIDTH-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_READ   = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                         insert_en;
      logic                         remove_en;
      logic                         read_en;
      logic        [POS_WIDTH-1:0]  position;
      logic signed [DATA_WIDTH-1:0] value;
   } iira_cell_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/iira_req_if.sv
// ---------------------------------------------------------------------------
// iira_req_if
// Request channel: valid/ready handshake carrying one array operation.
// ---------------------------------------------------------------------------
`default_nettype none

interface iira_req_if
   import iira_pkg::*;
   ();

   logic                         valid;
   logic                         ready;
   logic        [KIND_WIDTH-1:0] kind;
   logic        [POS_WIDTH-1:0]  position;
   logic signed [DATA_WIDTH-1:0] value;

   modport source (output valid, output kind, output position, output value,
                   input ready);
   modport sink   (input valid, input kind, input position, input value,
                   output ready);

endinterface

`default_nettype wire

FILE: rtl/iira_rsp_if.sv
// ---------------------------------------------------------------------------
// iira_rsp_if
// Response channel: valid/ready handshake carrying one operation result.
// ---------------------------------------------------------------------------
`default_nettype none

interface iira_rsp_if
   import iira_pkg::*;
   ();

   logic                           valid;
   logic                           ready;
   logic        [STATUS_WIDTH-1:0] status;
   logic        [FILL_WIDTH-1:0]   fill_count;
   logic signed [DATA_WIDTH-1:0]   read_value;

   modport source (output valid, output status, output fill_count,
                   output read_value, input ready);
   modport sink   (input valid, input status, input fill_count,
                   input read_value, output ready);

endinterface

`default_nettype wire

FILE: rtl/indexed_insert_remove_array.sv
// Response: registered from its request transaction, valid in the cycle after it.
// Throughput: one operation per cycle while no held response waits on the
//   response side; every cell shifts in parallel, so an insert or remove is as fast as a read.
// Reset: synchronous; clears the fill count and the response valid flag. The
//   cell contents are not reset and are only ever read once written.
// ---------------------------------------------------------------------------
// indexed_insert_remove_array
// Bounded ordered array of signed 32-bit elements held in a row of cells,
// supporting insert, remove and read at a position, with a fill count.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_insert_remove_array
   import iira_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   iira_req_if.sink  req_bus,
   iira_rsp_if.source rsp_bus
);

   // The fill count must hold the full capacity, so it is one bit wider than
   // a cell index when the capacity is a power of two.
   localparam int CNT_WIDTH = $clog2(CAPACITY + 1);
   localparam int CMP_WIDTH = (CNT_WIDTH > POS_WIDTH) ? CNT_WIDTH : POS_WIDTH;

   logic [CNT_WIDTH-1:0]    count_ff;
   logic [CNT_WIDTH-1:0]    count_in;

   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic [STATUS_WIDTH-1:0] status_in;
   logic [FILL_WIDTH-1:0]   fill_ff;
   logic signed [DATA_WIDTH-1:0] read_value_ff;
   logic signed [DATA_WIDTH-1:0] read_value_in;

   logic                    accept;
   logic [CMP_WIDTH-1:0]    pos_ext;
   logic [CMP_WIDTH-1:0]    cnt_ext;
   iira_cell_ctl_type       cell_ctl;

   logic signed [DATA_WIDTH-1:0] cell_data  [CAPACITY];
   logic signed [DATA_WIDTH-1:0] sel_data   [CAPACITY];
   logic signed [DATA_WIDTH-1:0] left_data  [CAPACITY];
   logic signed [DATA_WIDTH-1:0] right_data [CAPACITY];
   logic signed [DATA_WIDTH-1:0] read_or;

   // The response register decouples the two sides: a new request is taken
   // whenever the held response is absent or is being taken in this cycle.
   assign req_bus.ready = !reset && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   assign pos_ext = CMP_WIDTH'(req_bus.position);
   assign cnt_ext = CMP_WIDTH'(count_ff);

   // Decode the operation against the current fill count. A position check
   // always comes before the full check, and an unused kind is a range error.
   always_comb begin
      status_in          = ST_RANGE;
      count_in           = count_ff;
      cell_ctl.insert_en = 1'b0;
      cell_ctl.remove_en = 1'b0;
      cell_ctl.read_en   = 1'b0;
      cell_ctl.position  = req_bus.position;
      cell_ctl.value     = req_bus.value;
      case (req_bus.kind)
         KIND_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status_in = ST_RANGE;
            end else if (count_ff == CNT_WIDTH'(CAPACITY)) begin
               status_in = ST_FULL;
            end else begin
               status_in          = ST_DONE;
               count_in           = count_ff + CNT_WIDTH'(1);
               cell_ctl.insert_en = accept;
            end
         end
         KIND_REMOVE: begin
            if (pos_ext < cnt_ext) begin
               status_in          = ST_DONE;
               count_in           = count_ff - CNT_WIDTH'(1);
               cell_ctl.remove_en = accept;
            end
         end
         KIND_READ: begin
            if (pos_ext < cnt_ext) begin
               status_in        = ST_DONE;
               cell_ctl.read_en = 1'b1;
            end
         end
         default: begin
            status_in = ST_RANGE;
         end
      endcase
   end

   // The row of cells. The end cells see zero beyond the row; those words
   // only ever land in slots above the fill count.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_left_edge
         assign left_data[i] = '0;
      end else begin : g_left
         assign left_data[i] = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_right_edge
         assign right_data[i] = '0;
      end else begin : g_right
         assign right_data[i] = cell_data[i+1];
      end

      iira_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .left_data  (left_data[i]),
         .right_data (right_data[i]),
         .data       (cell_data[i]),
         .sel_data   (sel_data[i])
      );
   end

   // At most one cell drives a non-zero word, so an OR gathers the read.
   always_comb begin
      read_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_or = read_or | sel_data[i];
      end
   end

   assign read_value_in = read_or;
   assign rsp_valid_in  = accept || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload is loaded with each accepted request transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         fill_ff       <= FILL_WIDTH'(count_in);
         read_value_ff <= read_value_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.status     = status_ff;
   assign rsp_bus.fill_count = fill_ff;
   assign rsp_bus.read_value = read_value_ff;

`ifndef SYNTH
   // The fill count never runs past the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(CAPACITY))
      else $error("fill count exceeds capacity");

   // A successful insert grows the fill count by exactly one.
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      accept && (req_bus.kind == KIND_INSERT) && (status_in == ST_DONE)
      |=> count_ff == $past(count_ff) + CNT_WIDTH'(1))
      else $error("insert did not grow the fill count by one");

   // A rejected transaction leaves the fill count untouched.
   a_reject_stable: assert property (@(posedge clock) disable iff (reset)
      accept && (status_in != ST_DONE) |=> $stable(count_ff))
      else $error("rejected transaction changed the fill count");

   // A failed transaction returns a zero read value.
   a_read_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff != ST_DONE) |-> read_value_ff == '0)
      else $error("non-zero read value on a failed transaction");
`endif

endmodule

`default_nettype wire

FILE: rtl/iira_cell.sv
// ---------------------------------------------------------------------------
// iira_cell
// One storage slot of the array. It loads the new element, takes its lower
// neighbour on an insert below it, or its upper neighbour on a remove at or
// below it.
// ---------------------------------------------------------------------------
`default_nettype none

module iira_cell
   import iira_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  wire logic                         clock,
   input  wire iira_cell_ctl_type            ctl,
   input  wire logic signed [DATA_WIDTH-1:0] left_data,
   input  wire logic signed [DATA_WIDTH-1:0] right_data,
   output      logic signed [DATA_WIDTH-1:0] data,
   output      logic signed [DATA_WIDTH-1:0] sel_data
);

   localparam logic [POS_WIDTH-1:0] CELL_POS = POS_WIDTH'(INDEX);

   logic signed [DATA_WIDTH-1:0] data_ff;
   logic signed [DATA_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.insert_en) begin
         if (ctl.position == CELL_POS) begin
            data_in = ctl.value;
         end else if (CELL_POS > ctl.position) begin
            data_in = left_data;
         end
      end else if (ctl.remove_en && (CELL_POS >= ctl.position)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   // Only the addressed cell drives a non-zero word onto the read OR-tree.
   assign sel_data = (ctl.read_en && (ctl.position == CELL_POS)) ? data_ff : '0;

endmodule

`default_nettype wire
